>>> hdl/sfr_pkg.sv
// Package for the serial frame receiver: shared constants, reset values
// and the result record. No dependencies; all files but sfr_if use it.
`default_nettype none

package sfr_pkg;

	// Frame layout and decoding constants.
	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] PUMP_BIT    = 8'h20;
	localparam logic [7:0] TEST_BIT    = 8'h40;
	localparam logic [7:0] DRAIN_BIT   = 8'h10;
	localparam logic [7:0] LEVEL_MASK  = 8'h07;

	// Frame byte positions whose values are captured for the result.
	localparam int POS_LEVEL = 2;
	localparam int POS_TEMP  = 3;
	localparam int POS_ERROR = 5;
	localparam int POS_LINK  = 6;

	// Defaults.
	localparam int          BUFFER_DEPTH_DEF = 64;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd10;
	localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

	// Item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// One decoded frame result.
	typedef struct packed {
		logic       frame_status;
		logic [2:0] water_level;
		logic       pump_flag;
		logic       test_mode;
		logic       drain_level_flag;
		logic [7:0] water_temp;
		logic [7:0] temp_error;
		logic [7:0] link_state;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/sfr_if.sv
// Valid/ready channel interfaces for the serial frame receiver: the input
// request channel and the result channel. Depends on nothing.
`default_nettype none

interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic       frame_status;
	logic [2:0] water_level;
	logic       pump_flag;
	logic       test_mode;
	logic       drain_level_flag;
	logic [7:0] water_temp;
	logic [7:0] temp_error;
	logic [7:0] link_state;

	modport source (output valid, output frame_status, output water_level,
		output pump_flag, output test_mode, output drain_level_flag,
		output water_temp, output temp_error, output link_state, input ready);
	modport sink   (input valid, input frame_status, input water_level,
		input pump_flag, input test_mode, input drain_level_flag,
		input water_temp, input temp_error, input link_state, output ready);
endinterface

`default_nettype wire

>>> hdl/sfr_frame_core.sv
// Frame state of the serial frame receiver: header hunt, byte storage,
// running checksum, idle counter and result decode. Depends on sfr_pkg.
`default_nettype none

module sfr_frame_core #(
	parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [15:0]     cfg_wdata,
	input  wire logic            item_take,
	input  wire logic            item_kind,
	input  wire logic [7:0]      item_byte,
	output logic                 res_push,
	output sfr_pkg::result_t     res_data
);

	localparam int PW = $clog2(BUFFER_DEPTH);
	localparam logic [PW-1:0] POS_FULL  = PW'(BUFFER_DEPTH - 1);
	localparam logic [PW-1:0] POS_LEVEL = PW'(sfr_pkg::POS_LEVEL);
	localparam logic [PW-1:0] POS_TEMP  = PW'(sfr_pkg::POS_TEMP);
	localparam logic [PW-1:0] POS_ERROR = PW'(sfr_pkg::POS_ERROR);
	localparam logic [PW-1:0] POS_LINK  = PW'(sfr_pkg::POS_LINK);

	logic [15:0]   timeout_q;
	logic          open_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic [7:0]    last_q;
	logic [7:0]    cap_level_q, cap_temp_q, cap_error_q, cap_link_q;
	logic [15:0]   idle_q;

	logic [15:0] idle_inc;
	logic        is_tick;
	logic        closing;
	logic        pass;

	assign is_tick  = item_take && (item_kind == sfr_pkg::KIND_TICK);
	assign idle_inc = (idle_q == sfr_pkg::COUNT_MAX) ? idle_q : idle_q + 16'd1;
	assign closing  = is_tick && open_q && (idle_inc > timeout_q);
	assign pass     = (sum_q == last_q);

	always_comb begin
		res_push = closing;
		res_data = '0;
		if (pass) begin
			res_data.frame_status     = 1'b0;
			res_data.water_level      = 3'(cap_level_q & sfr_pkg::LEVEL_MASK);
			res_data.pump_flag        = |(cap_level_q & sfr_pkg::PUMP_BIT);
			res_data.test_mode        = |(cap_level_q & sfr_pkg::TEST_BIT);
			res_data.drain_level_flag = |(cap_level_q & sfr_pkg::DRAIN_BIT);
			res_data.water_temp       = cap_temp_q;
			res_data.temp_error       = cap_error_q;
			res_data.link_state       = cap_link_q;
		end else begin
			res_data.frame_status = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= sfr_pkg::TIMEOUT_RESET;
			open_q      <= 1'b0;
			pos_q       <= '0;
			sum_q       <= '0;
			last_q      <= '0;
			cap_level_q <= '0;
			cap_temp_q  <= '0;
			cap_error_q <= '0;
			cap_link_q  <= '0;
			idle_q      <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (item_take && item_kind == sfr_pkg::KIND_BYTE) begin
				idle_q <= '0;
				if (!open_q) begin
					if (item_byte == sfr_pkg::HEADER_BYTE) begin
						open_q <= 1'b1;
						pos_q  <= PW'(1);
						sum_q  <= '0;
						last_q <= item_byte;
					end
				end else if (pos_q < POS_FULL) begin
					if (pos_q == POS_LEVEL) cap_level_q <= item_byte;
					if (pos_q == POS_TEMP)  cap_temp_q  <= item_byte;
					if (pos_q == POS_ERROR) cap_error_q <= item_byte;
					if (pos_q == POS_LINK)  cap_link_q  <= item_byte;
					sum_q  <= sum_q + last_q;
					last_q <= item_byte;
					pos_q  <= pos_q + PW'(1);
				end
			end else if (is_tick) begin
				idle_q <= idle_inc;
				if (closing) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/sfr_out_buf.sv
// Two-entry result buffer (output register plus skid register) that lets
// the input side keep accepting while a result waits. Depends on sfr_pkg.
`default_nettype none

module sfr_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfr_pkg::result_t push_data,
	output logic                  space,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sfr_pkg::result_t      out_data
);

	logic             main_v_q, skid_v_q;
	sfr_pkg::result_t main_q, skid_q;
	logic             pop;

	assign pop       = main_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || pop) begin
				if (skid_v_q) begin
					main_v_q <= 1'b1;
					main_q   <= skid_q;
					skid_v_q <= push;
					skid_q   <= push_data;
				end else begin
					main_v_q <= push;
					main_q   <= push_data;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
				skid_q   <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/serial_frame_receiver_with_timeout.sv
// Top level of the serial frame receiver with idle timeout.
// Depends on sfr_pkg, sfr_if, sfr_frame_core and sfr_out_buf.
`default_nettype none

// Each request on the input channel is either a received serial byte
// (kind 0) or a one millisecond tick (kind 1), and one request is taken in
// every clock cycle while the output side has space; the frame state
// updates in the cycle a request is accepted. While no frame is open,
// bytes other than the header 0xAA are dropped; the header opens a frame
// and later bytes are stored until BUFFER_DEPTH-1 bytes are held, after
// which extra bytes are ignored but still restart the idle count. Ticks
// count idle time, saturating at 65535; the tick that pushes the count
// above idle_timeout closes an open frame and produces exactly one result
// request. The frame passes when its last stored byte equals the 8-bit sum
// of the bytes before it; a pass reports the decoded bytes 2, 3, 5 and 6,
// and a failure reports frame_status 1 with all other fields zero. Bytes
// 2, 3, 5 and 6 persist across frames, so a short frame reports whatever
// was captured earlier. A result is registered into the output register,
// or into the skid register while the output register is held, before it
// appears on the output channel. The output side holds up to two results
// (an output register and a skid register); the input stalls only when both
// are occupied. idle_timeout resets to 10; the user must write it through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce it.

module serial_frame_receiver_with_timeout #(
	parameter int BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	sfr_in_if.sink           in_ch,
	sfr_out_if.source        out_ch
);

	logic             item_take;
	logic             res_push;
	logic             buf_space;
	sfr_pkg::result_t res_data;
	sfr_pkg::result_t out_data;

	// A request is taken whenever the skid register is free, so a tick that
	// closes a frame always has a place for its result.
	assign in_ch.ready = buf_space;
	assign item_take   = in_ch.valid && buf_space;

	sfr_frame_core #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_take (item_take),
		.item_kind (in_ch.kind),
		.item_byte (in_ch.rx_byte),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	sfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.space     (buf_space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_data)
	);

	// Unpack the held result onto the channel fields.
	assign out_ch.frame_status     = out_data.frame_status;
	assign out_ch.water_level      = out_data.water_level;
	assign out_ch.pump_flag        = out_data.pump_flag;
	assign out_ch.test_mode        = out_data.test_mode;
	assign out_ch.drain_level_flag = out_data.drain_level_flag;
	assign out_ch.water_temp       = out_data.water_temp;
	assign out_ch.temp_error       = out_data.temp_error;
	assign out_ch.link_state       = out_data.link_state;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for serial_frame_receiver_with_timeout.
// It depends on sfr_pkg and the channel interfaces in sfr_if. A small class
// tracks the frame state and compares every result with its own prediction.

class frame_tracker;
	// Copy of the block's frame state and its one register.
	logic [15:0] timeout     = sfr_pkg::TIMEOUT_RESET;
	logic        frame_open  = 1'b0;
	int          write_pos   = 0;
	logic [7:0]  running_sum = 8'h00;
	logic [7:0]  last_byte   = 8'h00;
	logic [7:0]  captured[4] = '{default: 8'h00};
	logic [15:0] idle_count  = 16'd0;

	sfr_pkg::result_t pending_frames[$];
	int errors        = 0;
	int frames_passed = 0;
	int frames_failed = 0;

	function void set_timeout(logic [15:0] value);
		timeout = value;
	endfunction

	// Updates the frame state for one accepted request and queues the
	// result that a closing tick produces.
	function void absorb_request(logic kind, logic [7:0] b);
		sfr_pkg::result_t r;
		logic [7:0] lv;
		if (kind == sfr_pkg::KIND_BYTE) begin
			idle_count = 16'd0;
			if (!frame_open) begin
				if (b == sfr_pkg::HEADER_BYTE) begin
					frame_open  = 1'b1;
					write_pos   = 1;
					running_sum = 8'h00;
					last_byte   = b;
				end
				return;
			end
			if (write_pos < sfr_pkg::BUFFER_DEPTH_DEF - 1) begin
				case (write_pos)
					sfr_pkg::POS_LEVEL: captured[0] = b;
					sfr_pkg::POS_TEMP:  captured[1] = b;
					sfr_pkg::POS_ERROR: captured[2] = b;
					sfr_pkg::POS_LINK:  captured[3] = b;
					default: ;
				endcase
				running_sum = running_sum + last_byte;
				last_byte   = b;
				write_pos++;
			end
			return;
		end
		if (idle_count != sfr_pkg::COUNT_MAX)
			idle_count++;
		if (!frame_open || idle_count <= timeout)
			return;
		frame_open = 1'b0;
		r = '0;
		if (running_sum != last_byte) begin
			r.frame_status = 1'b1;
		end else begin
			lv                 = captured[0];
			r.water_level      = lv[2:0] & sfr_pkg::LEVEL_MASK[2:0];
			r.pump_flag        = |(lv & sfr_pkg::PUMP_BIT);
			r.test_mode        = |(lv & sfr_pkg::TEST_BIT);
			r.drain_level_flag = |(lv & sfr_pkg::DRAIN_BIT);
			r.water_temp       = captured[1];
			r.temp_error       = captured[2];
			r.link_state       = captured[3];
		end
		pending_frames.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares one accepted result with the oldest queued one.
	function void match_result(sfr_pkg::result_t got);
		sfr_pkg::result_t want;
		if (pending_frames.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = pending_frames.pop_front();
		compare_field("frame_status", want.frame_status, got.frame_status);
		compare_field("water_level", want.water_level, got.water_level);
		compare_field("pump_flag", want.pump_flag, got.pump_flag);
		compare_field("test_mode", want.test_mode, got.test_mode);
		compare_field("drain_level_flag", want.drain_level_flag, got.drain_level_flag);
		compare_field("water_temp", want.water_temp, got.water_temp);
		compare_field("temp_error", want.temp_error, got.temp_error);
		compare_field("link_state", want.link_state, got.link_state);
		if (want.frame_status)
			frames_failed++;
		else
			frames_passed++;
	endfunction
endclass

module testbench;

	// QUIET_LIMIT sets how long the watchdog waits, in cycles in which neither
	// channel moves a request, before it gives up. The longest legal quiet
	// stretch is the receiver hold-off of HOLD_CYCLES together with its settling.
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 440;
	localparam int SETTLE_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	sfr_in_if  in_ch();
	sfr_out_if out_ch();

	serial_frame_receiver_with_timeout dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	frame_tracker board = new;

	// Percent chances, per cycle, that the sender idles and that the
	// receiver stalls. The main sequence changes them phase by phase.
	int idle_pct  = 0;
	int stall_pct = 0;
	// Set by the main sequence to ask the receiver for a long hold-off.
	int hold_request = 0;
	int requests_sent = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sends one request, idling at random first. The request is accepted at
	// the first rising edge at which ready is high; ready is looked at on
	// the falling edge before, where it has settled. Valid stays high on
	// return so that back-to-back requests leave no gap.
	task automatic send_request(logic kind, logic [7:0] b);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.kind    <= kind;
		in_ch.rx_byte <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end
		board.absorb_request(kind, b);
		requests_sent++;
	endtask

	// Ticks carry a random rx_byte, which the block must ignore.
	task automatic send_ticks(int count);
		repeat (count)
			send_request(sfr_pkg::KIND_TICK, 8'($urandom_range(255)));
	endtask

	// Stops the sender and waits until every predicted result has arrived.
	task automatic pause_until_drained();
		in_ch.valid <= 1'b0;
		while (board.pending_frames.size() != 0)
			@(posedge clk);
	endtask

	// Writes idle_timeout while the block is idle. A tick that closes
	// nothing leaves no trace to wait for, so a settling wait comes before
	// the write in any case.
	task automatic write_timeout(logic [15:0] value);
		pause_until_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_timeout(value);
	endtask

	// Sends one frame of total_len bytes, the header included. With good_sum
	// the last byte that the buffer keeps carries the correct checksum; any
	// bytes after a full buffer are extra. Short tick runs that stay within
	// the timeout fall between bytes now and then, and a few runs are long
	// enough to close the frame early. The frame is then closed by ticks.
	task automatic send_frame(int total_len, bit good_sum, int t_out);
		int last_pos;
		int gap_max;
		logic [7:0] sum;
		logic [7:0] b;
		last_pos = (total_len < sfr_pkg::BUFFER_DEPTH_DEF ? total_len :
			sfr_pkg::BUFFER_DEPTH_DEF - 1) - 1;
		gap_max  = t_out < 12 ? t_out : 12;
		sum      = 8'h00;
		for (int i = 0; i < total_len; i++) begin
			if (i == 0)
				b = sfr_pkg::HEADER_BYTE;
			else if (i == last_pos && good_sum)
				b = sum;
			else
				b = 8'($urandom_range(255));
			sum = sum + b;
			send_request(sfr_pkg::KIND_BYTE, b);
			if ($urandom_range(99) < 12)
				send_ticks($urandom_range(gap_max));
			else if ($urandom_range(99) < 3)
				send_ticks(t_out + 1);
		end
		send_ticks(t_out + 1 + $urandom_range(2));
	endtask

	// Mostly short frames, some medium, a few of 60 to 72 bytes around the buffer size.
	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 10);
		else if (r < 90)
			return $urandom_range(11, 40);
		return $urandom_range(60, 72);
	endfunction

	// One step of random traffic: a frame most of the time, otherwise a
	// stray byte or a short run of ticks.
	task automatic random_traffic(int t_out);
		int r;
		r = $urandom_range(99);
		if (r < 80)
			send_frame(pick_length(), $urandom_range(99) < 70, t_out);
		else if (r < 90)
			send_request(sfr_pkg::KIND_BYTE, 8'($urandom_range(255)));
		else
			send_ticks($urandom_range(1, 3));
	endtask

	// Receiver: checks each accepted result and drives ready. The handshake
	// and the fields are looked at on the falling edge before the rising
	// edge that takes them. A hold-off, once asked for, is counted down here
	// so that the sender keeps offering requests while the output side
	// fills up.
	initial begin
		sfr_pkg::result_t got;
		int hold_left;
		logic taken;
		hold_left    = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			taken                = arst_n && out_ch.valid && out_ch.ready;
			got.frame_status     = out_ch.frame_status;
			got.water_level      = out_ch.water_level;
			got.pump_flag        = out_ch.pump_flag;
			got.test_mode        = out_ch.test_mode;
			got.drain_level_flag = out_ch.drain_level_flag;
			got.water_temp       = out_ch.water_temp;
			got.temp_error       = out_ch.temp_error;
			got.link_state       = out_ch.link_state;
			@(posedge clk);
			if (taken)
				board.match_result(got);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no request moves on either channel for
	// too long, which catches a hung handshake or a missing result.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired, %0d results still outstanding", $time,
			board.pending_frames.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0] pattern[7];
		logic [7:0] sum;
		int idle_mix[4];
		int stall_mix[4];
		int phase_end;
		int half_way;
		int failures;

		idle_mix  = '{0, 64, 0, 32};
		stall_mix = '{0, 0, 64, 32};
		pattern   = '{8'hAA, 8'h01, 8'hAA, 8'hFF, 8'h00, 8'h55, 8'h80};

		// Every input starts at a known value while reset is held.
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 16'd0;
		in_ch.valid   = 1'b0;
		in_ch.kind    = sfr_pkg::KIND_BYTE;
		in_ch.rx_byte = 8'h00;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With a zero timeout a single tick closes a frame.
		write_timeout(16'd0);
		// Bytes other than the header are dropped while no frame is open,
		// and a tick without an open frame produces nothing.
		send_request(sfr_pkg::KIND_BYTE, 8'h00);
		send_request(sfr_pkg::KIND_BYTE, 8'hFF);
		send_ticks(1);
		// A frame holding only the header always fails.
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_ticks(1);
		// A passing frame that carries the header value as data byte 2, 0xFF in
		// captured byte 3 and 0x00 in the uncaptured byte 4.
		sum = 8'h00;
		foreach (pattern[i]) begin
			send_request(sfr_pkg::KIND_BYTE, pattern[i]);
			sum = sum + pattern[i];
		end
		send_request(sfr_pkg::KIND_BYTE, sum);
		send_ticks(1);
		// A short frame that passes reports the bytes kept from before.
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_ticks(1);
		// A checksum mismatch zeroes every field but the status.
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_request(sfr_pkg::KIND_BYTE, 8'h01);
		send_request(sfr_pkg::KIND_BYTE, 8'h02);
		send_request(sfr_pkg::KIND_BYTE, 8'h03);
		send_ticks(1);
		// With a timeout of one, a byte between ticks restarts the count.
		write_timeout(16'd1);
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_ticks(1);
		send_request(sfr_pkg::KIND_BYTE, 8'h5A);
		send_ticks(2);

		// With the largest timeout the idle count can never exceed it, so
		// the frame stays open through a run of silence. A small timeout
		// written afterwards lets the very next tick close it.
		write_timeout(16'hFFFF);
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
		send_ticks(20);
		write_timeout(16'd5);
		send_ticks(1);

		// Random part in four phases of idling and stalling, each with two
		// timeout settings.
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_mix[p];
			stall_pct = stall_mix[p];
			if (p == 0) begin
				// The receiver holds off while header-only frames keep coming,
				// so the output side fills and the input stalls. The sender
				// then waits for every result before going on.
				write_timeout(16'd0);
				hold_request = HOLD_CYCLES;
				repeat (20) begin
					send_request(sfr_pkg::KIND_BYTE, sfr_pkg::HEADER_BYTE);
					send_ticks(1);
				end
				pause_until_drained();
			end
			phase_end = requests_sent + PHASE_ITEMS;
			half_way  = requests_sent + PHASE_ITEMS / 2;
			case (p)
				0: write_timeout(16'd3);
				1: write_timeout(16'd1);
				2: write_timeout(16'd2);
				default: write_timeout(16'($urandom_range(6)));
			endcase
			while (requests_sent < half_way)
				random_traffic(board.timeout);
			case (p)
				0: write_timeout(16'd0);
				1: write_timeout(16'd10);
				2: write_timeout(16'd0);
				default: write_timeout(16'd5);
			endcase
			while (requests_sent < phase_end)
				random_traffic(board.timeout);
		end

		// Drain, then give the output side time to show any stray result.
		pause_until_drained();
		repeat (16)
			@(posedge clk);

		failures = board.errors + board.pending_frames.size();
		$display("Sent %0d requests; checked %0d frame results (%0d good checksum, %0d bad).",
			requests_sent, board.frames_passed + board.frames_failed,
			board.frames_passed, board.frames_failed);
		$display("Timeouts ranged from 0 to 65535 under four mixes of sender idling and stalls.");
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
